>>> rtl/hds_pkg.sv
// Shared types, constants and helpers for the heat diffusion stencil core.
// No dependencies; every other file in rtl/ but hds_ram uses this package.
package hds_pkg;

	// Grid limits and field widths
	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int DIM_W       = 11;
	localparam int TEMP_W      = 32;
	localparam int DIFF_W      = 16;
	localparam int DT_W        = 16;
	localparam int KD_W        = DIFF_W + DT_W;
	localparam int IN_W        = 48;
	localparam int OUT_W       = 56;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Row buffers: three temperature rows, two diffusivity rows
	localparam int TEMP_DEPTH  = 3 * MAX_COLS;
	localparam int DIFF_DEPTH  = 2 * MAX_COLS;
	localparam int TADDR_W     = COL_W + 2;
	localparam int DADDR_W     = COL_W + 1;

	// Arithmetic widths
	localparam int SUM_W       = TEMP_W + 2;
	localparam int LAP_W       = TEMP_W + 3;
	localparam int PROD_W      = LAP_W + 17;
	localparam int TOT_W       = PROD_W + 16;
	localparam int INC_W       = TOT_W - 32;
	localparam int RES_W       = INC_W + 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd2;

	localparam logic [DT_W-1:0]  DT_RESET   = 16'd6554;
	localparam logic [DIM_W-1:0] DIM_RESET  = 11'd1024;

	// Number of stencil reads per cell
	localparam logic [2:0] READ_N = 3'd5;

	typedef struct packed {
		logic [COL_W-1:0] cols_m1;
		logic [ROW_W-1:0] rows_m1;
	} geom_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [1:0]       row3;
		logic [COL_W-1:0] col;
		logic             last;
	} cmd_t;

	typedef enum logic {
		F_IDLE,
		F_EMIT
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_KD,
		B_MHI,
		B_MLO,
		B_ADD,
		B_FIN,
		B_DONE
	} back_state_t;

	function automatic logic [1:0] mod3_inc(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic [1:0] mod3_dec(input logic [1:0] v);
		return (v == 2'd0) ? 2'd2 : v - 2'd1;
	endfunction

endpackage

>>> rtl/hds_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/hds_cmd_fifo.sv
// Short command queue between the front and back sections.
// Depends on hds_pkg (cmd_t).
module hds_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hds_pkg::cmd_t push_cmd,
	input  logic          pop,
	output hds_pkg::cmd_t pop_cmd,
	output logic          empty
);

	hds_pkg::cmd_t mem_q [4];
	logic [1:0]    wptr_q;
	logic [1:0]    rptr_q;
	logic [2:0]    count_q;

	assign empty   = (count_q == 3'd0);
	assign pop_cmd = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/hds_front.sv
// Front section: accepts cells, writes the row buffers, tracks raster position
// and queues the cells to compute. Depends on hds_pkg.
module hds_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hds_pkg::IN_W-1:0]      s_tdata,
	input  hds_pkg::geom_t                geom,
	input  logic                          restart,
	input  logic                          back_idle,
	input  logic                          fifo_empty,
	output logic                          t_we,
	output logic [hds_pkg::TADDR_W-1:0]   t_waddr,
	output logic [hds_pkg::TEMP_W-1:0]    t_wdata,
	output logic                          d_we,
	output logic [hds_pkg::DADDR_W-1:0]   d_waddr,
	output logic [hds_pkg::DIFF_W-1:0]    d_wdata,
	output logic                          push,
	output hds_pkg::cmd_t                 push_cmd
);

	hds_pkg::front_state_t state_q, state_d;
	logic [hds_pkg::COL_W-1:0] col_q;
	logic [hds_pkg::ROW_W-1:0] row_q;
	logic [1:0]                r3_q;
	logic [2:0]                pend_q;
	logic [2:0]                pend_next;
	logic [2:0]                flags;
	logic                      accept;
	logic                      last_row;
	hds_pkg::cmd_t             cmd0_q, cmd1_q, cmd2_q;

	assign accept    = s_tvalid && s_tready;
	assign last_row  = (row_q == geom.rows_m1);
	assign pend_next = pend_q & (pend_q - 3'd1);

	// which finished cells this input releases: above, left in last row, itself
	assign flags[0] = (row_q != '0);
	assign flags[1] = last_row && (col_q != '0);
	assign flags[2] = last_row && (col_q == geom.cols_m1);

	// row buffer writes
	assign t_we    = accept;
	assign t_waddr = {r3_q, col_q};
	assign t_wdata = s_tdata[hds_pkg::TEMP_W-1:0];
	assign d_we    = accept;
	assign d_waddr = {row_q[0], col_q};
	assign d_wdata = s_tdata[hds_pkg::TEMP_W +: hds_pkg::DIFF_W];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hds_pkg::F_IDLE: begin
				if (accept && (flags != 3'd0)) begin
					state_d = hds_pkg::F_EMIT;
				end
			end
			hds_pkg::F_EMIT: begin
				if (pend_next == 3'd0) begin
					state_d = hds_pkg::F_IDLE;
				end
			end
			default: state_d = hds_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		push     = 1'b0;
		push_cmd = cmd2_q;
		case (state_q)
			hds_pkg::F_IDLE: begin
				s_tready = fifo_empty && back_idle;
			end
			hds_pkg::F_EMIT: begin
				push = (pend_q != 3'd0);
				if (pend_q[0]) begin
					push_cmd = cmd0_q;
				end else if (pend_q[1]) begin
					push_cmd = cmd1_q;
				end
			end
			default: s_tready = 1'b0;
		endcase
	end

	// pending commands
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd0_q <= '{row: row_q - 1'b1, row3: hds_pkg::mod3_dec(r3_q),
				col: col_q, last: 1'b0};
			cmd1_q <= '{row: row_q, row3: r3_q, col: col_q - 1'b1, last: 1'b0};
			cmd2_q <= '{row: row_q, row3: r3_q, col: col_q, last: 1'b1};
		end
	end

	// control state and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hds_pkg::F_IDLE;
			pend_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			r3_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pend_q <= flags;
			end else if (push) begin
				pend_q <= pend_next;
			end
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
				r3_q  <= '0;
			end else if (accept) begin
				if (col_q == geom.cols_m1) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						r3_q  <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						r3_q  <= hds_pkg::mod3_inc(r3_q);
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/hds_back.sv
// Back section: reads the five-point stencil, forms the update with a shared
// multiplier, saturates and holds the result in the output register.
// Depends on hds_pkg.
module hds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fifo_empty,
	input  hds_pkg::cmd_t                 cmd,
	output logic                          pop,
	output logic                          back_idle,
	input  hds_pkg::geom_t                geom,
	input  logic [hds_pkg::DT_W-1:0]      dt,
	output logic                          t_re,
	output logic [hds_pkg::TADDR_W-1:0]   t_raddr,
	input  logic [hds_pkg::TEMP_W-1:0]    t_rdata,
	output logic                          d_re,
	output logic [hds_pkg::DADDR_W-1:0]   d_raddr,
	input  logic [hds_pkg::DIFF_W-1:0]    d_rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hds_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tlast
);

	hds_pkg::back_state_t state_q, state_d;
	hds_pkg::cmd_t        cmd_q;
	logic [2:0]           cnt_q;

	logic signed [hds_pkg::TEMP_W-1:0] center_q;
	logic signed [hds_pkg::SUM_W-1:0]  sum_q;
	logic signed [hds_pkg::LAP_W-1:0]  lap_q;
	logic [hds_pkg::KD_W-1:0]          kd_q;
	logic signed [hds_pkg::PROD_W-1:0] p_hi_q, p_lo_q, prod;
	logic signed [hds_pkg::INC_W-1:0]  inc_q;
	logic signed [hds_pkg::TOT_W-1:0]  total;
	logic signed [hds_pkg::RES_W-1:0]  res_wide;
	logic [hds_pkg::TEMP_W-1:0]        res_q;
	logic [15:0]                       mul_b;
	logic                              load_out;

	logic [1:0]                ym3, yp3;
	logic [hds_pkg::COL_W-1:0] xm, xp;

	// mirrored neighbor positions
	assign ym3 = (cmd_q.row == '0) ? hds_pkg::mod3_inc(cmd_q.row3)
		: hds_pkg::mod3_dec(cmd_q.row3);
	assign yp3 = (cmd_q.row == geom.rows_m1) ? hds_pkg::mod3_dec(cmd_q.row3)
		: hds_pkg::mod3_inc(cmd_q.row3);
	assign xm  = (cmd_q.col == '0) ? hds_pkg::COL_W'(1) : cmd_q.col - 1'b1;
	assign xp  = (cmd_q.col == geom.cols_m1) ? cmd_q.col - 1'b1 : cmd_q.col + 1'b1;

	// read order: center, north, south, west, east
	always_comb begin
		case (cnt_q)
			3'd1:    t_raddr = {ym3, cmd_q.col};
			3'd2:    t_raddr = {yp3, cmd_q.col};
			3'd3:    t_raddr = {cmd_q.row3, xm};
			3'd4:    t_raddr = {cmd_q.row3, xp};
			default: t_raddr = {cmd_q.row3, cmd_q.col};
		endcase
	end
	assign d_raddr = {cmd_q.row[0], cmd_q.col};

	// shared multiplier: laplacian times one half of K*dt
	assign mul_b = (state_q == hds_pkg::B_MHI) ? kd_q[31:16] : kd_q[15:0];
	assign prod  = lap_q * $signed({1'b0, mul_b});

	// rounding add: (lap*kd + 2^31) >> 32, floor
	assign total = $signed({p_hi_q, 16'b0}) + {{16{p_lo_q[hds_pkg::PROD_W-1]}}, p_lo_q}
		+ hds_pkg::TOT_W'(64'h8000_0000);
	assign res_wide = {{(hds_pkg::RES_W - hds_pkg::TEMP_W){center_q[hds_pkg::TEMP_W-1]}},
		center_q} + {inc_q[hds_pkg::INC_W-1], inc_q};

	assign load_out = (state_q == hds_pkg::B_DONE) && (!m_tvalid || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hds_pkg::B_IDLE: if (!fifo_empty) state_d = hds_pkg::B_READ;
			hds_pkg::B_READ: if (cnt_q == hds_pkg::READ_N) state_d = hds_pkg::B_KD;
			hds_pkg::B_KD:   state_d = hds_pkg::B_MHI;
			hds_pkg::B_MHI:  state_d = hds_pkg::B_MLO;
			hds_pkg::B_MLO:  state_d = hds_pkg::B_ADD;
			hds_pkg::B_ADD:  state_d = hds_pkg::B_FIN;
			hds_pkg::B_FIN:  state_d = hds_pkg::B_DONE;
			hds_pkg::B_DONE: if (load_out) state_d = hds_pkg::B_IDLE;
			default:         state_d = hds_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		back_idle = 1'b0;
		t_re      = 1'b0;
		d_re      = 1'b0;
		case (state_q)
			hds_pkg::B_IDLE: begin
				back_idle = 1'b1;
				pop       = !fifo_empty;
			end
			hds_pkg::B_READ: begin
				t_re = (cnt_q < hds_pkg::READ_N);
				d_re = (cnt_q == 3'd0);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			hds_pkg::B_IDLE: begin
				cmd_q <= cmd;
				sum_q <= '0;
			end
			hds_pkg::B_READ: begin
				if (cnt_q == 3'd1) begin
					center_q <= t_rdata;
				end else if (cnt_q != 3'd0) begin
					sum_q <= sum_q + {{2{t_rdata[hds_pkg::TEMP_W-1]}}, t_rdata};
				end
			end
			hds_pkg::B_KD: begin
				kd_q  <= d_rdata * dt;
				lap_q <= {sum_q[hds_pkg::SUM_W-1], sum_q}
					- {center_q[hds_pkg::TEMP_W-1], center_q, 2'b00};
			end
			hds_pkg::B_MHI: p_hi_q <= prod;
			hds_pkg::B_MLO: p_lo_q <= prod;
			hds_pkg::B_ADD: inc_q  <= total[hds_pkg::TOT_W-1:32];
			hds_pkg::B_FIN: begin
				if (res_wide > $signed(hds_pkg::RES_W'(32'sh7FFF_FFFF))) begin
					res_q <= 32'h7FFF_FFFF;
				end else if (res_wide < -$signed(hds_pkg::RES_W'(64'h8000_0000))) begin
					res_q <= 32'h8000_0000;
				end else begin
					res_q <= res_wide[hds_pkg::TEMP_W-1:0];
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
		if (load_out) begin
			m_tdata <= {4'b0, cmd_q.row, cmd_q.col, res_q};
			m_tlast <= cmd_q.last;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hds_pkg::B_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hds_pkg::B_READ) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/heat_diffusion_stencil_core.sv
// One cell is computed at a time through five reads of the row buffer's read port;
// an input that releases cells is followed by the next accept only once all of
// them have been computed and the back section is idle again.
// Reset (arst_n low, asynchronous): counters and handshakes clear, registers
// return to dt 6554 and a 1024 x 1024 grid; the row buffers keep no reset.
module heat_diffusion_stencil_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hds_pkg::IN_W-1:0]          s_tdata,   // cell_temp, cell_diffusivity
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hds_pkg::OUT_W-1:0]         m_tdata,   // next_temp, out_col, out_row
	output logic                              m_tlast,   // frame_last
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hds_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [hds_pkg::DT_W-1:0]  dt_q;
	logic [hds_pkg::DIM_W-1:0] cols_q, rows_q;
	logic [hds_pkg::DIM_W-1:0] nc, nr;
	logic                      cfg_wr, restart;
	hds_pkg::geom_t            geom;

	logic                          t_we, t_re, d_we, d_re;
	logic [hds_pkg::TADDR_W-1:0]   t_waddr, t_raddr;
	logic [hds_pkg::DADDR_W-1:0]   d_waddr, d_raddr;
	logic [hds_pkg::TEMP_W-1:0]    t_wdata, t_rdata;
	logic [hds_pkg::DIFF_W-1:0]    d_wdata, d_rdata;
	logic                          push, pop, fifo_empty, back_idle;
	hds_pkg::cmd_t                 push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && ((cfg_index == hds_pkg::CFG_GRID_COLS)
		|| (cfg_index == hds_pkg::CFG_GRID_ROWS));

	// clamp grid size to the supported range
	assign nc = (cols_q < 11'd2) ? 11'd2
		: (cols_q > hds_pkg::DIM_W'(hds_pkg::MAX_COLS)) ? hds_pkg::DIM_W'(hds_pkg::MAX_COLS)
		: cols_q;
	assign nr = (rows_q < 11'd2) ? 11'd2
		: (rows_q > hds_pkg::DIM_W'(hds_pkg::MAX_ROWS)) ? hds_pkg::DIM_W'(hds_pkg::MAX_ROWS)
		: rows_q;
	assign geom.cols_m1 = hds_pkg::COL_W'(nc - 11'd1);
	assign geom.rows_m1 = hds_pkg::ROW_W'(nr - 11'd1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= hds_pkg::DT_RESET;
			cols_q <= hds_pkg::DIM_RESET;
			rows_q <= hds_pkg::DIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				hds_pkg::CFG_TIME_STEP: dt_q   <= cfg_data;
				hds_pkg::CFG_GRID_COLS: cols_q <= cfg_data[hds_pkg::DIM_W-1:0];
				hds_pkg::CFG_GRID_ROWS: rows_q <= cfg_data[hds_pkg::DIM_W-1:0];
				default:                dt_q   <= dt_q;
			endcase
		end
	end

	hds_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .geom, .restart,
		.back_idle, .fifo_empty, .t_we, .t_waddr, .t_wdata,
		.d_we, .d_waddr, .d_wdata, .push, .push_cmd
	);

	hds_cmd_fifo u_fifo (
		.clk, .arst_n, .push, .push_cmd, .pop, .pop_cmd, .empty(fifo_empty)
	);

	hds_ram #(.WIDTH(hds_pkg::TEMP_W), .DEPTH(hds_pkg::TEMP_DEPTH)) u_temp_rows (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rdata)
	);

	hds_ram #(.WIDTH(hds_pkg::DIFF_W), .DEPTH(hds_pkg::DIFF_DEPTH)) u_diff_rows (
		.clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rdata)
	);

	hds_back u_back (
		.clk, .arst_n, .fifo_empty, .cmd(pop_cmd), .pop, .back_idle, .geom,
		.dt(dt_q), .t_re, .t_raddr, .t_rdata, .d_re, .d_raddr, .d_rdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

endmodule

>>> rtl/hds_checker.sv
// Port-level checks for the stencil core, bound to the top level.
// Depends on hds_pkg for port widths.
module hds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hds_pkg::OUT_W-1:0]     m_tdata,
	input logic                          m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// padding above the row field stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[55:52] == 4'd0))
		else $error("result padding not zero");

	// the last cell sits at least at row 1, column 1
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[41:32] != 10'd0) && (m_tdata[51:42] != 10'd0))
		else $error("frame end on first row or column");

	// no result right out of reset
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid after reset");

endmodule

bind heat_diffusion_stencil_core hds_checker u_hds_checker (.*);

>>> bench/tb_heat_diffusion_stencil_core.sv
// Testbench for heat_diffusion_stencil_core: streams raster-ordered grids through the core
// and checks every emitted cell against an in-bench model of the five-point update or a given expected value.
// Depends on hds_pkg and the core RTL.
module tb_heat_diffusion_stencil_core;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct {
		logic [31:0]               temp;
		logic [hds_pkg::COL_W-1:0] col;
		logic [hds_pkg::ROW_W-1:0] row;
		logic                      last;
	} cell_out_t;

	typedef struct {
		logic [31:0] temp;
		logic [15:0] diff;
		bit          typed;
		logic [31:0] typed_temp;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [hds_pkg::IN_W-1:0]       s_tdata = '0;   // cell_temp, cell_diffusivity
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [hds_pkg::OUT_W-1:0]      m_tdata;        // next_temp, out_col, out_row
	logic                           m_tlast;        // frame_last
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [hds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	heat_diffusion_stencil_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state: row buffers, raster position, registers
	longint          temp_buf [3*hds_pkg::MAX_COLS];
	int unsigned     diff_buf [2*hds_pkg::MAX_COLS];
	int unsigned     pos_col, pos_row;
	logic [15:0]     dt_reg;
	logic [10:0]     cols_reg, rows_reg;
	cell_out_t       pending_cells[$];
	int              mismatches = 0;
	int              idle_cycles = 0;
	bit              no_idle = 0;

	function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
		if (v < 2) return 2;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic longint temp_at(int unsigned y, int unsigned x);
		return temp_buf[(y % 3) * hds_pkg::MAX_COLS + x];
	endfunction

	// Five-point update of one cell with rounding and saturation
	function automatic logic [31:0] diffuse_cell(int unsigned y, int unsigned x,
			int unsigned nc, int unsigned nr);
		int unsigned    ym, yp, xm, xp;
		longint         c, lap, hi, lo, s, res;
		longint unsigned kd;
		ym = (y == 0) ? 1 : y - 1;
		yp = (y + 1 >= nr) ? nr - 2 : y + 1;
		xm = (x == 0) ? 1 : x - 1;
		xp = (x + 1 >= nc) ? nc - 2 : x + 1;
		c = temp_at(y, x);
		lap = temp_at(ym, x) + temp_at(yp, x) + temp_at(y, xm) + temp_at(y, xp) - 4 * c;
		kd = longint'(diff_buf[(y % 2) * hds_pkg::MAX_COLS + x]) * longint'(dt_reg);
		hi = longint'(kd >> 16);
		lo = longint'(kd & 64'hFFFF);
		s = lap * hi + ((lap * lo) >>> 16);
		res = c + ((s + 32768) >>> 16);
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		return res[31:0];
	endfunction

	task automatic queue_cell(int unsigned y, int unsigned x, int unsigned nc,
			int unsigned nr, bit typed, logic [31:0] typed_temp);
		cell_out_t e;
		e.temp = typed ? typed_temp : diffuse_cell(y, x, nc, nr);
		e.col  = x[hds_pkg::COL_W-1:0];
		e.row  = y[hds_pkg::ROW_W-1:0];
		e.last = (y == nr - 1 && x == nc - 1);
		pending_cells.push_back(e);
	endtask

	// Store one accepted cell and queue the cells it releases
	task automatic absorb_cell(logic [31:0] t, logic [15:0] k, bit typed, logic [31:0] tv);
		int unsigned nc, nr, c, r;
		nc = clamp_dim(cols_reg, hds_pkg::MAX_COLS);
		nr = clamp_dim(rows_reg, hds_pkg::MAX_ROWS);
		c = (pos_col >= nc) ? nc - 1 : pos_col;
		r = (pos_row >= nr) ? nr - 1 : pos_row;
		temp_buf[(r % 3) * hds_pkg::MAX_COLS + c] = longint'(signed'(t));
		diff_buf[(r % 2) * hds_pkg::MAX_COLS + c] = k;
		if (r >= 1) queue_cell(r - 1, c, nc, nr, typed, tv);
		if (r == nr - 1 && c >= 1) queue_cell(r, c - 1, nc, nr, typed, tv);
		if (r == nr - 1 && c == nc - 1) queue_cell(r, c, nc, nr, typed, tv);
		c++;
		if (c >= nc) begin
			c = 0;
			r++;
			if (r >= nr) r = 0;
		end
		pos_col = c;
		pos_row = r;
	endtask

	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_cell(logic [31:0] t, logic [15:0] k, bit typed, logic [31:0] tv);
		int gap;
		s_tdata  <= {k, t};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_cell(t, k, typed, tv);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [hds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			hds_pkg::CFG_TIME_STEP: dt_reg = val;
			hds_pkg::CFG_GRID_COLS: begin
				cols_reg = val[10:0];
				pos_col = 0;
				pos_row = 0;
			end
			hds_pkg::CFG_GRID_ROWS: begin
				rows_reg = val[10:0];
				pos_col = 0;
				pos_row = 0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Wait until every queued cell has come out, then let the core settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_temp();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 32'h7FFF_FFFF;
		if (p == 1) return 32'h8000_0000;
		if (p < 6) return $urandom;
		return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
	endfunction

	function automatic logic [15:0] dim_word(int unsigned d);
		logic [4:0] junk;
		junk = 5'($urandom_range(0, 31));
		return {junk, d[10:0]};
	endfunction

	// Result checker and downstream stall pattern
	int stall_left = 0;
	always @(posedge clk) begin
		cell_out_t e;
		if (m_tvalid && m_tready) begin
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected cell temp=%h col=%0d row=%0d last=%b", $time,
					m_tdata[31:0], m_tdata[41:32], m_tdata[51:42], m_tlast);
				mismatches++;
			end else begin
				e = pending_cells.pop_front();
				if (m_tdata[31:0] !== e.temp) begin
					$display("%0t: next_temp expected %h actual %h", $time, e.temp, m_tdata[31:0]);
					mismatches++;
				end
				if (m_tdata[41:32] !== e.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time, e.col, m_tdata[41:32]);
					mismatches++;
				end
				if (m_tdata[51:42] !== e.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time, e.row, m_tdata[51:42]);
					mismatches++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: frame_last expected %b actual %b", $time, e.last, m_tlast);
					mismatches++;
				end
			end
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!no_idle) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: stall_left <= $urandom_range(1, 3);
					4:          stall_left <= $urandom_range(10, 40);
					default:    ;
				endcase
			end
		end
	end

	// Watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	dir_row_t dir_tab [16];

	initial begin
		int unsigned nc, nr, frame_n, n, cut, rand_items;
		logic [31:0] mx, mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		foreach (temp_buf[i]) temp_buf[i] = 0;
		foreach (diff_buf[i]) diff_buf[i] = 0;
		pos_col = 0;
		pos_row = 0;
		dt_reg = hds_pkg::DT_RESET;
		cols_reg = hds_pkg::DIM_RESET;
		rows_reg = hds_pkg::DIM_RESET;

		// Uniform frames at both extremes, then a saturating checkerboard, then K = 0
		for (int i = 0; i < 4; i++) dir_tab[i] = '{mx, 16'hFFFF, 1, mx};
		for (int i = 4; i < 8; i++) dir_tab[i] = '{mn, 16'hFFFF, 1, mn};
		dir_tab[8]  = '{mx, 16'hFFFF, 0, 0};
		dir_tab[9]  = '{mn, 16'hFFFF, 0, 0};
		dir_tab[10] = '{mn, 16'hFFFF, 0, 0};
		dir_tab[11] = '{mx, 16'hFFFF, 0, 0};
		dir_tab[12] = '{32'h0001_0000, 16'h0000, 0, 0};
		dir_tab[13] = '{32'hFFFF_0000, 16'h0000, 0, 0};
		dir_tab[14] = '{32'h0000_0000, 16'h0000, 0, 0};
		dir_tab[15] = '{32'h1234_5678, 16'h0000, 0, 0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Undersized dimensions clamp to a 2 x 2 grid; index 3 is ignored
		write_reg(2'd3, 16'hFFFF);
		write_reg(hds_pkg::CFG_TIME_STEP, 16'hFFFF);
		write_reg(hds_pkg::CFG_GRID_COLS, 16'd1);
		write_reg(hds_pkg::CFG_GRID_ROWS, 16'd0);
		foreach (dir_tab[i])
			send_cell(dir_tab[i].temp, dir_tab[i].diff, dir_tab[i].typed, dir_tab[i].typed_temp);
		drain();

		// Narrow, tall grid (oversized row count clamps), part of a frame
		write_reg(hds_pkg::CFG_TIME_STEP, 16'd6554);
		write_reg(hds_pkg::CFG_GRID_COLS, 16'd2);
		write_reg(hds_pkg::CFG_GRID_ROWS, 16'h07FF);
		for (int i = 0; i < 100; i++) send_cell(rand_temp(), 16'($urandom), 1'b0, '0);
		drain();

		// Random small grids, whole frames with the odd frame cut short
		rand_items = 0;
		while (rand_items < 230) begin
			no_idle = ($urandom_range(0, 4) == 0);
			nc = $urandom_range(2, 6);
			nr = $urandom_range(2, 6);
			if ($urandom_range(0, 2) != 0)
				write_reg(hds_pkg::CFG_TIME_STEP, ($urandom_range(0, 5) == 0) ?
					16'hFFFF : 16'($urandom));
			if ($urandom_range(0, 1)) begin
				write_reg(hds_pkg::CFG_GRID_COLS, dim_word(nc));
				write_reg(hds_pkg::CFG_GRID_ROWS, dim_word(nr));
			end else begin
				write_reg(hds_pkg::CFG_GRID_ROWS, dim_word(nr));
				write_reg(hds_pkg::CFG_GRID_COLS, dim_word(nc));
			end
			frame_n = nc * nr;
			n = frame_n * $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0) n += $urandom_range(1, frame_n - 1);
			cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : n;
			for (int i = 0; i < n; i++) begin
				if (i == cut) begin
					s_tvalid <= 1'b0;
					while (pending_cells.size() != 0) @(posedge clk);
				end
				send_cell(rand_temp(), 16'($urandom), 1'b0, '0);
				rand_items++;
			end
			drain();
		end
		no_idle = 0;

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// A cell is left waiting if the core stops producing; the watchdog covers that
	initial begin
		@(posedge arst_n);
	end
endmodule

>>> filelist.f
rtl/hds_pkg.sv
rtl/hds_ram.sv
rtl/hds_cmd_fifo.sv
rtl/hds_front.sv
rtl/hds_back.sv
rtl/heat_diffusion_stencil_core.sv
rtl/hds_checker.sv
bench/tb_heat_diffusion_stencil_core.sv
